### src/positional_audio_gain_pan_doppler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional audio gain, pan and doppler block.
// The macros expect the signals clk and rst to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_AUDIO_GAIN_PAN_DOPPLER_ASSERT_SVH
`define POSITIONAL_AUDIO_GAIN_PAN_DOPPLER_ASSERT_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define PAGPD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never hold outside reset.
`define PAGPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

### src/pagpd_pkg.sv
// ----------------------------------------------------------------------------
// pagpd_pkg
// Types, register indexes and fixed-point constants of the positional audio
// gain, pan and doppler block.
// ----------------------------------------------------------------------------
package pagpd_pkg;

  typedef struct packed {
    logic signed [23:0] source_x;
    logic signed [23:0] source_y;
    logic signed [23:0] listener_x;
    logic signed [23:0] listener_y;
    logic signed [23:0] source_vx;
    logic signed [23:0] source_vy;
    logic signed [23:0] listener_vx;
    logic signed [23:0] listener_vy;
  } in_item_t;

  typedef struct packed {
    logic [15:0] track_gain;
    logic [15:0] left_gain;
    logic [15:0] right_gain;
    logic [23:0] frequency_ratio;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_INV_LOG_MAX_DIST = 2'd0,
    REG_VOLUME           = 2'd1,
    REG_PLAYBACK_SPEED   = 2'd2,
    REG_SOUND_SPEED      = 2'd3
  } cfg_reg_t;

  localparam int CfgDataW = 23;

  localparam logic [19:0] INV_LOG_RESET  = 20'd0;
  localparam logic [15:0] VOLUME_RESET   = 16'd4096;
  localparam logic [15:0] SPEED_RESET    = 16'd4096;
  localparam logic [22:0] SOUND_RESET    = 23'd87808;

  // log10(2) in Q.32.
  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913987;

  // Odd sine polynomial coefficients in Q.30, highest order first.
  localparam logic [30:0] SIN_C9 = 31'd172272;
  localparam logic [30:0] SIN_COEF [4] = '{31'd5026995, 31'd85569306,
                                          31'd693598668, 31'd1686629713};

endpackage

### src/positional_audio_gain_pan_doppler.sv
// ----------------------------------------------------------------------------
// Positional audio gain, pan and doppler ratio, fully pipelined.
// A word is taken in every cycle while busy is low; its result shows on done.
// The pipe depth is set by the square root, the radial divider and the ratio
// divider, which retire one bit per stage. Synchronous reset restores the
// registers and empties the pipeline; busy is high in the cycle after reset.
// ----------------------------------------------------------------------------
module positional_audio_gain_pan_doppler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  pagpd_pkg::in_item_t                item,
  output logic                               done,
  output pagpd_pkg::out_item_t               result,
  input  logic                               cfg_we,
  input  pagpd_pkg::cfg_reg_t                cfg_index,
  input  logic [pagpd_pkg::CfgDataW-1:0]     cfg_data
);
  import pagpd_pkg::*;

  localparam int SqrtSteps  = 25;
  localparam int LogSteps   = 16;
  localparam int PanSteps   = 16;
  localparam int RadSteps   = 27;
  localparam int RatioSteps = 24;
  localparam int TDist      = 2 + SqrtSteps;
  localparam int TGain      = TDist + 1 + LogSteps + 4;
  localparam int TPan       = TDist + 1 + PanSteps + 8;
  localparam int TDenom     = TDist + 1 + RadSteps + 1;
  localparam int TRatio     = TDenom + 2 + RatioSteps;
  localparam int TOut       = TRatio + 1;

  // Configuration and control.
  logic [19:0]      inv_log_max_dist;
  logic [15:0]      volume;
  logic [15:0]      playback_speed;
  logic [22:0]      sound_speed;
  logic [TOut:0]    vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_log_max_dist <= INV_LOG_RESET;
      volume           <= VOLUME_RESET;
      playback_speed   <= SPEED_RESET;
      sound_speed      <= SOUND_RESET;
      vld              <= '0;
      busy             <= 1'b1;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[TOut-1:0], start & ~busy};
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INV_LOG_MAX_DIST: inv_log_max_dist <= cfg_data[19:0];
          REG_VOLUME:           volume           <= cfg_data[15:0];
          REG_PLAYBACK_SPEED:   playback_speed   <= cfg_data[15:0];
          REG_SOUND_SPEED:      sound_speed      <= cfg_data[22:0];
          default:              volume           <= volume;
        endcase
      end
    end
  end

  assign done = vld[TOut];

  // Differences, squares and the radial dot product.
  logic signed [24:0] dx0, dy0, rvx0, rvy0;
  logic [24:0]        adx_c, ady_c;
  logic [49:0]        adx2, ady2;
  logic signed [49:0] px1, py1;
  logic [24:0]        adx1;
  logic               neg1;

  always_comb begin
    adx_c = dx0[24] ? 25'(-dx0) : 25'(dx0);
    ady_c = dy0[24] ? 25'(-dy0) : 25'(dy0);
  end

  // Square root, one result bit per stage.
  logic [26:0]        sq_rem  [SqrtSteps+1];
  logic [24:0]        sq_root [SqrtSteps+1];
  logic [49:0]        sq_val  [SqrtSteps+1];
  logic [24:0]        sq_adx  [SqrtSteps+1];
  logic               sq_neg  [SqrtSteps+1];
  logic signed [50:0] sq_rad  [SqrtSteps+1];
  logic [28:0]        sq_rs    [SqrtSteps];
  logic [28:0]        sq_trial [SqrtSteps];

  always_comb begin
    for (int j = 0; j < SqrtSteps; j++) begin
      sq_rs[j]    = {sq_rem[j], sq_val[j][49:48]};
      sq_trial[j] = {2'b00, sq_root[j], 2'b01};
    end
  end

  // Log2 of dist + 1 by repeated squaring of the normalized mantissa.
  logic [25:0] lx;
  logic [4:0]  ln_c;
  logic [30:0] lm_c;
  logic [30:0] lg_m [LogSteps+1];
  logic [4:0]  lg_n [LogSteps+1];
  logic [15:0] lg_f [LogSteps+1];
  logic [61:0] lg_sq [LogSteps];
  logic [51:0] lmul;
  logic [20:0] l10_c;
  logic [40:0] prod;
  logic [32:0] g32_c;
  logic [48:0] gmul;
  logic [49:0] gsum_c;

  always_comb begin
    lx   = 26'(sq_root[SqrtSteps]) + 26'd256;
    ln_c = '0;
    for (int b = 0; b < 26; b++) begin
      if (lx[b]) ln_c = 5'(b);
    end
    lm_c = 31'(lx) << (5'd30 - ln_c);
    for (int k = 0; k < LogSteps; k++) begin
      lg_sq[k] = lg_m[k] * lg_m[k];
    end
    l10_c  = 21'((53'(lmul) + (53'd1 << 31)) >> 32);
    g32_c  = (prod[40:32] != '0) ? 33'd0 : (33'd1 << 32) - 33'(prod);
    gsum_c = 50'(gmul) + (50'd1 << 31);
  end

  // Pan: |dx| / dist, one quotient bit per stage.
  logic [39:0] pn_c;
  logic [24:0] pd_rem  [PanSteps+1];
  logic [15:0] pd_low  [PanSteps+1];
  logic [15:0] pd_q    [PanSteps+1];
  logic [24:0] pd_dist [PanSteps+1];
  logic        pd_neg  [PanSteps+1];
  logic        pd_zero [PanSteps+1];
  logic [25:0] pd_rs   [PanSteps];
  logic [15:0] qc_c;
  logic [16:0] tr_c;

  // Sine lanes: index 0 is the left (cosine) side, 1 the right side.
  logic [16:0] sn_t   [2];
  logic [30:0] hp_p   [5][2];
  logic [30:0] hp_t2  [5][2];
  logic [30:0] hp_t30 [5][2];
  logic [61:0] hp_m   [4][2];
  logic [61:0] t2sq_c [2];
  logic [61:0] sm_c   [2];
  logic [31:0] sn_s   [2];
  logic [32:0] sr_c   [2];

  always_comb begin
    pn_c = {sq_adx[SqrtSteps], 15'd0} + 40'(sq_root[SqrtSteps] >> 1);
    for (int j = 0; j < PanSteps; j++) begin
      pd_rs[j] = {pd_rem[j], pd_low[j][15]};
    end
    qc_c = (pd_q[PanSteps] > 16'd32768) ? 16'd32768 : pd_q[PanSteps];
    if (pd_zero[PanSteps]) begin
      tr_c = 17'd32768;
    end else if (pd_neg[PanSteps]) begin
      tr_c = 17'd32768 - 17'(qc_c);
    end else begin
      tr_c = 17'd32768 + 17'(qc_c);
    end
    for (int l = 0; l < 2; l++) begin
      t2sq_c[l] = {sn_t[l], 14'd0} * {sn_t[l], 14'd0};
      for (int h = 0; h < 4; h++) begin
        hp_m[h][l] = hp_t2[h][l] * hp_p[h][l];
      end
      sm_c[l] = hp_t30[4][l] * hp_p[4][l];
      sr_c[l] = 33'(sn_s[l]) + (33'd1 << 14);
    end
  end

  logic [15:0] tg_dl [TGain:TRatio];
  logic [15:0] lg_dl [TPan:TRatio];
  logic [15:0] rg_dl [TPan:TRatio];

  // Radial speed: |v . d| / dist, one quotient bit per stage.
  logic [50:0] rmag_c;
  logic [24:0] rd_rem  [RadSteps+1];
  logic [26:0] rd_low  [RadSteps+1];
  logic [26:0] rd_q    [RadSteps+1];
  logic [24:0] rd_dist [RadSteps+1];
  logic        rd_neg  [RadSteps+1];
  logic        rd_zero [RadSteps+1];
  logic [25:0] rd_rs   [RadSteps];

  // Doppler ratio.
  logic [38:0]        nmul;
  logic signed [28:0] rad_c, lo_c, radc_c, dsum_c;
  logic [27:0]        dn;
  logic [43:0]        nsum_c;
  logic [27:0]        dv_rem [RatioSteps+1];
  logic [23:0]        dv_low [RatioSteps+1];
  logic [23:0]        dv_q   [RatioSteps+1];
  logic [27:0]        dv_d   [RatioSteps+1];
  logic               dv_sat [RatioSteps+1];
  logic [28:0]        dv_rs  [RatioSteps];
  logic [23:0]        fr;

  always_comb begin
    rmag_c = sq_rad[SqrtSteps][50] ? 51'(-sq_rad[SqrtSteps]) : 51'(sq_rad[SqrtSteps]);
    for (int j = 0; j < RadSteps; j++) begin
      rd_rs[j] = {rd_rem[j], rd_low[j][26]};
    end
    if (rd_zero[RadSteps]) begin
      rad_c = '0;
    end else if (rd_neg[RadSteps]) begin
      rad_c = -$signed({2'b00, rd_q[RadSteps]});
    end else begin
      rad_c = $signed({2'b00, rd_q[RadSteps]});
    end
    lo_c   = 29'sd256 - $signed({6'd0, sound_speed});
    radc_c = (rad_c < lo_c) ? lo_c : rad_c;
    dsum_c = $signed({6'd0, sound_speed}) + radc_c;
    nsum_c = 44'({nmul, 4'd0}) + 44'(dn[27:1]);
    for (int j = 0; j < RatioSteps; j++) begin
      dv_rs[j] = {dv_rem[j], dv_low[j][23]};
    end
  end

  always_ff @(posedge clk) begin
    // Input differences.
    dx0  <= 25'(item.source_x)  - 25'(item.listener_x);
    dy0  <= 25'(item.source_y)  - 25'(item.listener_y);
    rvx0 <= 25'(item.source_vx) - 25'(item.listener_vx);
    rvy0 <= 25'(item.source_vy) - 25'(item.listener_vy);

    adx2 <= adx_c * adx_c;
    ady2 <= ady_c * ady_c;
    px1  <= rvx0 * dx0;
    py1  <= rvy0 * dy0;
    adx1 <= adx_c;
    neg1 <= dx0[24];

    sq_val[0]  <= adx2 + ady2;
    sq_rad[0]  <= 51'(px1) + 51'(py1);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_adx[0]  <= adx1;
    sq_neg[0]  <= neg1;
    for (int j = 0; j < SqrtSteps; j++) begin
      if (sq_rs[j] >= sq_trial[j]) begin
        sq_rem[j+1]  <= 27'(sq_rs[j] - sq_trial[j]);
        sq_root[j+1] <= {sq_root[j][23:0], 1'b1};
      end else begin
        sq_rem[j+1]  <= sq_rs[j][26:0];
        sq_root[j+1] <= {sq_root[j][23:0], 1'b0};
      end
      sq_val[j+1] <= {sq_val[j][47:0], 2'b00};
      sq_adx[j+1] <= sq_adx[j];
      sq_neg[j+1] <= sq_neg[j];
      sq_rad[j+1] <= sq_rad[j];
    end

    // Distance gain.
    lg_m[0] <= lm_c;
    lg_n[0] <= ln_c;
    lg_f[0] <= '0;
    for (int k = 0; k < LogSteps; k++) begin
      if (lg_sq[k][61]) begin
        lg_m[k+1] <= lg_sq[k][61:31];
        lg_f[k+1] <= {lg_f[k][14:0], 1'b1};
      end else begin
        lg_m[k+1] <= lg_sq[k][60:30];
        lg_f[k+1] <= {lg_f[k][14:0], 1'b0};
      end
      lg_n[k+1] <= lg_n[k];
    end
    lmul <= {5'(lg_n[LogSteps] - 5'd8), lg_f[LogSteps]} * LOG10_2_Q32;
    prod <= l10_c * inv_log_max_dist;
    gmul <= volume * g32_c;
    tg_dl[TGain] <= (gsum_c[49:32] > 18'd65535) ? 16'hFFFF : gsum_c[47:32];
    for (int t = TGain + 1; t <= TRatio; t++) begin
      tg_dl[t] <= tg_dl[t-1];
    end

    // Pan divider.
    pd_rem[0]  <= {1'b0, pn_c[39:16]};
    pd_low[0]  <= pn_c[15:0];
    pd_q[0]    <= '0;
    pd_dist[0] <= sq_root[SqrtSteps];
    pd_neg[0]  <= sq_neg[SqrtSteps];
    pd_zero[0] <= (sq_root[SqrtSteps] == '0);
    for (int j = 0; j < PanSteps; j++) begin
      if (pd_rs[j] >= {1'b0, pd_dist[j]}) begin
        pd_rem[j+1] <= 25'(pd_rs[j] - {1'b0, pd_dist[j]});
        pd_q[j+1]   <= {pd_q[j][14:0], 1'b1};
      end else begin
        pd_rem[j+1] <= pd_rs[j][24:0];
        pd_q[j+1]   <= {pd_q[j][14:0], 1'b0};
      end
      pd_low[j+1]  <= {pd_low[j][14:0], 1'b0};
      pd_dist[j+1] <= pd_dist[j];
      pd_neg[j+1]  <= pd_neg[j];
      pd_zero[j+1] <= pd_zero[j];
    end

    // Equal-power pan through the quarter-wave sine polynomial.
    sn_t[0] <= 17'd65536 - tr_c;
    sn_t[1] <= tr_c;
    for (int l = 0; l < 2; l++) begin
      hp_t30[0][l] <= {sn_t[l], 14'd0};
      hp_t2[0][l]  <= t2sq_c[l][60:30];
      hp_p[0][l]   <= SIN_C9;
      for (int h = 0; h < 4; h++) begin
        hp_p[h+1][l]   <= SIN_COEF[h] - hp_m[h][l][60:30];
        hp_t2[h+1][l]  <= hp_t2[h][l];
        hp_t30[h+1][l] <= hp_t30[h][l];
      end
      sn_s[l] <= sm_c[l][61:30];
    end
    lg_dl[TPan] <= (sr_c[0][32:15] > 18'd32768) ? 16'd32768 : sr_c[0][30:15];
    rg_dl[TPan] <= (sr_c[1][32:15] > 18'd32768) ? 16'd32768 : sr_c[1][30:15];
    for (int t = TPan + 1; t <= TRatio; t++) begin
      lg_dl[t] <= lg_dl[t-1];
      rg_dl[t] <= rg_dl[t-1];
    end

    // Radial divider.
    rd_rem[0]  <= {1'b0, rmag_c[50:27]};
    rd_low[0]  <= rmag_c[26:0];
    rd_q[0]    <= '0;
    rd_dist[0] <= sq_root[SqrtSteps];
    rd_neg[0]  <= sq_rad[SqrtSteps][50];
    rd_zero[0] <= (sq_root[SqrtSteps] == '0);
    for (int j = 0; j < RadSteps; j++) begin
      if (rd_rs[j] >= {1'b0, rd_dist[j]}) begin
        rd_rem[j+1] <= 25'(rd_rs[j] - {1'b0, rd_dist[j]});
        rd_q[j+1]   <= {rd_q[j][25:0], 1'b1};
      end else begin
        rd_rem[j+1] <= rd_rs[j][24:0];
        rd_q[j+1]   <= {rd_q[j][25:0], 1'b0};
      end
      rd_low[j+1]  <= {rd_low[j][25:0], 1'b0};
      rd_dist[j+1] <= rd_dist[j];
      rd_neg[j+1]  <= rd_neg[j];
      rd_zero[j+1] <= rd_zero[j];
    end

    // Doppler ratio with rounding; a quotient of 2^24 or more saturates.
    nmul <= playback_speed * sound_speed;
    dn   <= dsum_c[27:0];
    dv_rem[0] <= {8'd0, nsum_c[43:24]};
    dv_low[0] <= nsum_c[23:0];
    dv_q[0]   <= '0;
    dv_d[0]   <= dn;
    dv_sat[0] <= ({8'd0, nsum_c[43:24]} >= dn);
    for (int j = 0; j < RatioSteps; j++) begin
      if (dv_rs[j] >= {1'b0, dv_d[j]}) begin
        dv_rem[j+1] <= 28'(dv_rs[j] - {1'b0, dv_d[j]});
        dv_q[j+1]   <= {dv_q[j][22:0], 1'b1};
      end else begin
        dv_rem[j+1] <= dv_rs[j][27:0];
        dv_q[j+1]   <= {dv_q[j][22:0], 1'b0};
      end
      dv_low[j+1] <= {dv_low[j][22:0], 1'b0};
      dv_d[j+1]   <= dv_d[j];
      dv_sat[j+1] <= dv_sat[j];
    end
    fr <= dv_sat[RatioSteps] ? 24'hFFFFFF : dv_q[RatioSteps];

    result.track_gain      <= tg_dl[TRatio];
    result.left_gain       <= lg_dl[TRatio];
    result.right_gain      <= rg_dl[TRatio];
    result.frequency_ratio <= fr;
  end

`include "positional_audio_gain_pan_doppler_assert.svh"

  `PAGPD_ASSERT_IMPLY(a_latency, done, $past(start && !busy, TOut + 1), "result without a word")
  `PAGPD_ASSERT_IMPLY(a_sqrt_rem, vld[TDist], sq_rem[SqrtSteps] <= {sq_root[SqrtSteps], 1'b0}, "sqrt remainder too large")
  `PAGPD_ASSERT_IMPLY(a_pan_rem, vld[TDist + 1 + PanSteps] && !pd_zero[PanSteps], pd_rem[PanSteps] < pd_dist[PanSteps], "pan divider remainder too large")
  `PAGPD_ASSERT_IMPLY(a_denom, vld[TDenom], dn >= 28'd256, "doppler denominator below one")
  `PAGPD_ASSERT_NEVER(a_pan_range, done && (result.left_gain > 16'd32768 || result.right_gain > 16'd32768), "pan gain above one")

endmodule

### tb/pagpd_checker.sv
// ----------------------------------------------------------------------------
// pagpd_checker
// Watches the command, result and register ports of the positional audio
// block, predicts the result of every accepted word in fixed point and
// compares it field by field with the results in order of arrival.
// ----------------------------------------------------------------------------
module pagpd_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  pagpd_pkg::in_item_t            item,
  input  logic                           done,
  input  pagpd_pkg::out_item_t           result,
  input  logic                           cfg_we,
  input  pagpd_pkg::cfg_reg_t            cfg_index,
  input  logic [pagpd_pkg::CfgDataW-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pagpd_pkg::*;

  logic [19:0] inv_log_q;
  logic [15:0] volume_q;
  logic [15:0] speed_q;
  logic [22:0] sound_q;
  out_item_t   gain_queue [$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log2_fix(longint unsigned x);
    int n;
    longint unsigned m;
    longint unsigned frac;
    n = 0;
    frac = 0;
    while ((x >> n) > 1) n++;
    m = x << (30 - n);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    return (longint'(n) << 16) | frac;
  endfunction

  function automatic longint unsigned quarter_sine(longint unsigned t);
    longint unsigned t30;
    longint unsigned t2;
    longint unsigned p;
    longint unsigned s;
    t30 = t << 14;
    t2 = (t30 * t30) >> 30;
    p = SIN_C9;
    for (int k = 0; k < 4; k++) p = SIN_COEF[k] - ((t2 * p) >> 30);
    s = (t30 * p) >> 30;
    s = (s + (64'd1 << 14)) >> 15;
    return (s > 32768) ? 64'd32768 : s;
  endfunction

  function automatic out_item_t predict_gains(in_item_t w);
    longint dx, dy, rvx, rvy, nx, radial, lo, rad_num;
    longint unsigned adx, ady, dist_q8, l10, prod, g32, gain, q, rm, t, c, num, denom, ratio;
    out_item_t r;
    dx  = longint'(w.source_x) - longint'(w.listener_x);
    dy  = longint'(w.source_y) - longint'(w.listener_y);
    rvx = longint'(w.source_vx) - longint'(w.listener_vx);
    rvy = longint'(w.source_vy) - longint'(w.listener_vy);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    dist_q8 = int_sqrt(adx * adx + ady * ady);
    nx = 0;
    radial = 0;

    l10 = log2_fix(dist_q8 + 256) - (64'd8 << 16);
    l10 = (l10 * LOG10_2_Q32 + (64'd1 << 31)) >> 32;
    prod = l10 * inv_log_q;
    g32 = (prod >= (64'd1 << 32)) ? 64'd0 : (64'd1 << 32) - prod;
    gain = (volume_q * g32 + (64'd1 << 31)) >> 32;
    r.track_gain = (gain > 65535) ? 16'hFFFF : gain[15:0];

    // A source on top of the listener has no direction: centred pan, no radial speed.
    if (dist_q8 != 0) begin
      q = (adx * 32768 + dist_q8 / 2) / dist_q8;
      if (q > 32768) q = 32768;
      nx = (dx < 0) ? -longint'(q) : longint'(q);
      rad_num = rvx * dx + rvy * dy;
      rm = ((rad_num < 0) ? -rad_num : rad_num) / dist_q8;
      radial = (rad_num < 0) ? -longint'(rm) : longint'(rm);
    end
    t = nx + 32768;
    r.left_gain  = 16'(quarter_sine(65536 - t));
    r.right_gain = 16'(quarter_sine(t));

    c = sound_q;
    lo = 256 - longint'(c);
    if (radial < lo) radial = lo;
    denom = longint'(c) + radial;
    num = (speed_q * c) << 4;
    ratio = (num + denom / 2) / denom;
    r.frequency_ratio = (ratio > 64'hFFFFFF) ? 24'hFFFFFF : ratio[23:0];
    return r;
  endfunction

  assign pending = gain_queue.size();

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst) begin
      inv_log_q  <= INV_LOG_RESET;
      volume_q   <= VOLUME_RESET;
      speed_q    <= SPEED_RESET;
      sound_q    <= SOUND_RESET;
      gain_queue.delete();
      fail_count <= 0;
    end else begin
      if (start && !busy) gain_queue.push_back(predict_gains(item));
      if (done) begin
        if (gain_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", result);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = gain_queue.pop_front();
          if (exp_r !== result) begin
            if (fail_count < 10)
              $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       exp_r.track_gain, exp_r.left_gain, exp_r.right_gain,
                       exp_r.frequency_ratio, result.track_gain, result.left_gain,
                       result.right_gain, result.frequency_ratio);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_INV_LOG_MAX_DIST: inv_log_q <= cfg_data[19:0];
          REG_VOLUME:           volume_q  <= cfg_data[15:0];
          REG_PLAYBACK_SPEED:   speed_q   <= cfg_data[15:0];
          REG_SOUND_SPEED:      sound_q   <= cfg_data[22:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/tb_positional_audio_gain_pan_doppler.sv
// ----------------------------------------------------------------------------
// tb_positional_audio_gain_pan_doppler
// Drives directed and random position words through the block under several
// register settings with random gaps; the checker predicts every result.
// ----------------------------------------------------------------------------
module tb_positional_audio_gain_pan_doppler;
  timeunit 1ns;
  timeprecision 1ps;
  import pagpd_pkg::*;

  localparam int DrainCycles = 100;
  localparam int CycleLimit  = 300000;

  localparam logic [19:0] InvSet [7] = '{20'd0, 20'hFFFFF, 20'd0, 20'h04000, 20'h10000,
                                         20'd0, 20'h05555};
  localparam logic [15:0] VolSet [7] = '{16'd4096, 16'hFFFF, 16'd0, 16'd4096, 16'h2000,
                                         16'd0, 16'hFFFF};
  localparam logic [15:0] SpdSet [7] = '{16'd4096, 16'hFFFF, 16'd0, 16'd4096, 16'h1800,
                                         16'd0, 16'h1000};
  localparam logic [22:0] SndSet [7] = '{23'd87808, 23'h7FFFFF, 23'd256, 23'd87808, 23'd0,
                                         23'd0, 23'd1};

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  in_item_t            item;
  logic                done;
  out_item_t           result;
  logic                cfg_we;
  cfg_reg_t            cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  pending;
  int                  cycle_count = 0;
  int                  word_count;

  positional_audio_gain_pan_doppler u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pagpd_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("positional_audio_gain_pan_doppler test failed");
      $finish;
    end
  end

  // Sends one word, idling for random cycles before it unless idling is off.
  task automatic send_word(in_item_t w, bit no_gap);
    while (!no_gap && $urandom_range(99) < 16) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
    word_count++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Register values but the sound speed carry random bits above their widths, which must be ignored.
  task automatic set_regs(logic [19:0] inv, logic [15:0] vol, logic [15:0] spd,
                          logic [22:0] snd);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    write_reg(REG_INV_LOG_MAX_DIST, {junk[22:20], inv});
    write_reg(REG_VOLUME, {junk[22:16], vol});
    write_reg(REG_PLAYBACK_SPEED, {junk[22:16], spd});
    write_reg(REG_SOUND_SPEED, snd);
  endtask

  function automatic in_item_t random_word();
    in_item_t w;
    logic [23:0] span;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(99) < 70) begin
      // Source near the listener so that gains and pan spread over their range.
      span = 24'hFFFFFF >> $urandom_range(4, 23);
      w.source_x = 24'(w.listener_x + ($urandom & span) - (span >> 1));
      w.source_y = 24'(w.listener_y + ($urandom & span) - (span >> 1));
      span = 24'hFFFFFF >> $urandom_range(6, 23);
      w.source_vx = 24'(($urandom & span) - (span >> 1));
      w.source_vy = 24'(($urandom & span) - (span >> 1));
      w.listener_vx = 24'(($urandom & span) - (span >> 1));
      w.listener_vy = 24'(($urandom & span) - (span >> 1));
    end
    return w;
  endfunction

  function automatic in_item_t make_word(int sx, int sy, int lx, int ly,
                                         int svx, int svy, int lvx, int lvy);
    in_item_t w;
    w.source_x = 24'(sx);   w.source_y = 24'(sy);
    w.listener_x = 24'(lx); w.listener_y = 24'(ly);
    w.source_vx = 24'(svx); w.source_vy = 24'(svy);
    w.listener_vx = 24'(lvx); w.listener_vy = 24'(lvy);
    return w;
  endfunction

  task automatic directed_words();
    int mx;
    int mn;
    mx = 8388607;
    mn = -8388608;
    send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_word(make_word(500, 500, 500, 500, 900, -30, 7, 7), 1'b0);
    send_word(make_word(256, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_word(make_word(-256, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_word(make_word(0, 256, 0, 0, 0, 0, 0, 0), 1'b0);
    send_word(make_word(1, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_word(make_word(mx, mx, mn, mn, mx, mx, mn, mn), 1'b0);
    send_word(make_word(mn, mn, mx, mx, mn, mn, mx, mx), 1'b0);
    send_word(make_word(mx, 0, mn, 0, mn, 0, mx, 0), 1'b0);
    send_word(make_word(mn, mx, mx, mn, 0, 0, 0, 0), 1'b0);
    send_word(make_word(25600, 0, 0, 0, -100000, 0, 0, 0), 1'b0);
    send_word(make_word(25600, 0, 0, 0, 100000, 0, 0, 0), 1'b0);
    send_word(make_word(-25600, 25600, 0, 0, 0, 0, mx, mn), 1'b0);
    send_word(make_word(3, 4, 0, 0, -1, -1, 1, 1), 1'b0);
    send_word(make_word(-1, -1, 0, 0, 0, 0, 0, 0), 1'b0);
    send_word(make_word(mx, mx, mx, mx, mn, mn, mx, mx), 1'b0);
    send_word(make_word(-1, -1, -1, -1, -1, -1, -1, -1), 1'b0);
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_INV_LOG_MAX_DIST;
    cfg_data    = '0;
    word_count  = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values first, then each setting in turn.
    for (int ph = 0; ph < 7; ph++) begin
      if (ph != 0) begin
        wait_drained();
        if (ph == 5)
          set_regs(20'($urandom), 16'($urandom), 16'($urandom),
                   23'($urandom_range(256, 8388607)));
        else
          set_regs(InvSet[ph], VolSet[ph], SpdSet[ph], SndSet[ph]);
      end
      if (ph < 2) directed_words();
      for (int n = 0; n < 250; n++) begin
        // Pause until the pipeline empties, once in the middle of phase 3.
        if (ph == 3 && n == 120) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_word(random_word(), ph == 2 && n >= 40 && n < 220);
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("positional_audio_gain_pan_doppler test passed");
    end else begin
      $display("positional_audio_gain_pan_doppler test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/pagpd_pkg.sv
src/positional_audio_gain_pan_doppler.sv
tb/pagpd_checker.sv
tb/tb_positional_audio_gain_pan_doppler.sv
